FILE: hw/rtl/mpat_pkg.sv
// Shared types and constants for the mesh path address table.
// Used by the slot cell, the controller, the top level and the testbench.
package mpat_pkg;

  localparam int MAC_BYTES     = 6;
  localparam int ADDR_W        = MAC_BYTES * 8;
  localparam int SIDX_W        = 5;
  localparam int STATION_W     = 8;
  localparam int MCAST_BIT     = ADDR_W - 8;
  localparam int MAX_PATHS_DEF = 32;

  typedef enum logic [1:0] {
    FN_LOOKUP  = 2'd0,
    FN_ADD     = 2'd1,
    FN_SET_HOP = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_OWN       = 3'd2,
    ST_MCAST     = 3'd3,
    ST_FULL      = 3'd4,
    ST_DUP       = 3'd5,
    ST_BAD_SLOT  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_WALK,
    CS_DONE
  } ctl_state_t;

  // Request token that walks the cell chain, gathering what each slot reports.
  typedef struct packed {
    logic                 valid;
    func_t                func;
    logic [ADDR_W-1:0]    addr;
    logic [SIDX_W-1:0]    sidx;
    logic [STATION_W-1:0] station;
    logic                 hit;
    logic                 hop_set;
    logic [STATION_W-1:0] hop;
    logic                 has_free;
    logic                 sel_used;
  } token_t;

  // Table update broadcast from the controller to every cell.
  typedef struct packed {
    logic                 add;
    logic                 hop;
    logic [ADDR_W-1:0]    addr;
    logic [STATION_W-1:0] station;
  } wr_t;

endpackage

FILE: hw/rtl/mpat_req_if.sv
// Request channel of the mesh path address table.
// Depends on nothing; field widths follow the table's request format.
interface mpat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [47:0] dest_address;
  logic [4:0]  slot_index;
  logic [7:0]  next_hop_station;

  modport source (output valid, func, dest_address, slot_index, next_hop_station,
                  input ready);
  modport sink   (input valid, func, dest_address, slot_index, next_hop_station,
                  output ready);
endinterface

FILE: hw/rtl/mpat_rsp_if.sv
// Response channel of the mesh path address table.
// Depends on nothing; field widths follow the table's response format.
interface mpat_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       found;
  logic [4:0] result_slot;
  logic       hop_valid;
  logic [7:0] hop_station;
  logic [5:0] path_count;

  modport source (output valid, status, found, result_slot, hop_valid, hop_station,
                  path_count, input ready);
  modport sink   (input valid, status, found, result_slot, hop_valid, hop_station,
                  path_count, output ready);
endinterface

FILE: hw/rtl/mpat_cfg_if.sv
// Configuration write channel carrying this node's own MAC address.
// Depends on nothing.
interface mpat_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] own_address;

  modport source (output valid, own_address, input ready);
  modport sink   (input valid, own_address, output ready);
endinterface

FILE: hw/rtl/mpat_cell.sv
// One table slot: holds an address and next hop, inspects the passing token.
// Depends on mpat_pkg.
module mpat_cell #(
  parameter int MAX_PATHS = mpat_pkg::MAX_PATHS_DEF,
  parameter int CELL_IDX  = 0,
  localparam int IDX_W    = $clog2(MAX_PATHS)
) (
  input  logic              clk,
  input  logic              rst,
  input  mpat_pkg::token_t  tok_in,
  input  logic [IDX_W-1:0]  hit_slot_in,
  input  logic [IDX_W-1:0]  free_slot_in,
  output mpat_pkg::token_t  tok_out,
  output logic [IDX_W-1:0]  hit_slot_out,
  output logic [IDX_W-1:0]  free_slot_out,
  input  mpat_pkg::wr_t     wr,
  input  logic [IDX_W-1:0]  wr_slot
);
  import mpat_pkg::*;

  localparam logic [IDX_W-1:0]   HERE      = IDX_W'(CELL_IDX);
  localparam logic [IDX_W+4:0]   HERE_WIDE = (IDX_W + 5)'(CELL_IDX);

  logic                 used;
  logic                 hop_set;
  logic [ADDR_W-1:0]    addr;
  logic [STATION_W-1:0] hop;

  token_t           tok_next;
  logic [IDX_W-1:0] hit_slot_next;
  logic [IDX_W-1:0] free_slot_next;
  logic             selected;

  always_comb begin
    tok_next       = tok_in;
    hit_slot_next  = hit_slot_in;
    free_slot_next = free_slot_in;
    selected       = ((IDX_W + 5)'(tok_in.sidx) == HERE_WIDE);
    // Lower slots were visited first, so the first hit on the way is the lowest one.
    if (used && !tok_in.hit && (tok_in.addr == addr)) begin
      tok_next.hit     = 1'b1;
      tok_next.hop_set = hop_set;
      tok_next.hop     = hop_set ? hop : '0;
      hit_slot_next    = HERE;
    end
    if (!used && !tok_in.has_free) begin
      tok_next.has_free = 1'b1;
      free_slot_next    = HERE;
    end
    if (selected) begin
      tok_next.sel_used = used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    hit_slot_out  <= hit_slot_next;
    free_slot_out <= free_slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      hop_set <= 1'b0;
    end else if (wr.add && (wr_slot == HERE)) begin
      used    <= 1'b1;
      hop_set <= 1'b0;
    end else if (wr.hop && (wr_slot == HERE)) begin
      hop_set <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.add && (wr_slot == HERE)) begin
      addr <= wr.addr;
    end
    if (wr.hop && (wr_slot == HERE)) begin
      hop <= wr.station;
    end
  end

endmodule

FILE: hw/rtl/mpat_ctrl.sv
// Controller: takes requests, launches tokens into the cell chain, decides the
// outcome from the returning token, updates the table and holds the response.
// Depends on mpat_pkg and the three channel interfaces.
module mpat_ctrl #(
  parameter int MAX_PATHS = mpat_pkg::MAX_PATHS_DEF,
  localparam int IDX_W    = $clog2(MAX_PATHS)
) (
  input  logic              clk,
  input  logic              rst,
  mpat_req_if.sink          req,
  mpat_rsp_if.source        rsp,
  mpat_cfg_if.sink          cfg,
  output mpat_pkg::token_t  head,
  input  mpat_pkg::token_t  tail,
  input  logic [IDX_W-1:0]  tail_hit_slot,
  input  logic [IDX_W-1:0]  tail_free_slot,
  output mpat_pkg::wr_t     wr,
  output logic [IDX_W-1:0]  wr_slot
);
  import mpat_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATHS + 1);

  ctl_state_t state, state_next;

  logic [ADDR_W-1:0]    own_address;
  logic [CNT_W-1:0]     count, count_next;
  token_t               fin;
  logic [IDX_W-1:0]     fin_hit_slot;
  logic [IDX_W-1:0]     fin_free_slot;

  logic                 rsp_valid;
  status_t              out_status;
  logic                 out_found;
  logic [IDX_W-1:0]     out_slot;
  logic                 out_hop_valid;
  logic [STATION_W-1:0] out_hop;
  logic [CNT_W-1:0]     out_count;

  status_t              res_status;
  logic                 res_found;
  logic [IDX_W-1:0]     res_slot;
  logic                 res_hop_valid;
  logic [STATION_W-1:0] res_hop;
  logic                 full;
  logic                 load;
  logic [IDX_W+4:0]     sidx_wide;
  logic [IDX_W+4:0]     slot_wide;
  logic [CNT_W+5:0]     count_wide;

  assign req.ready = (state == CS_IDLE) && !rst;
  assign cfg.ready = !rst;

  always_comb begin
    head          = '0;
    head.valid    = req.valid && req.ready;
    head.func     = func_t'(req.func);
    head.addr     = req.dest_address;
    head.sidx     = req.slot_index;
    head.station  = req.next_hop_station;
  end

  assign load = (state == CS_DONE) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: if (req.valid) state_next = CS_WALK;
      CS_WALK: if (tail.valid) state_next = CS_DONE;
      CS_DONE: if (load) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    sidx_wide     = {{IDX_W{1'b0}}, fin.sidx};
    full          = (count == CNT_W'(MAX_PATHS));
    res_status    = ST_OK;
    res_found     = 1'b0;
    res_slot      = '0;
    res_hop_valid = 1'b0;
    res_hop       = '0;
    wr            = '0;
    wr.addr       = fin.addr;
    wr.station    = fin.station;
    wr_slot       = '0;
    count_next    = count;
    unique case (fin.func)
      FN_LOOKUP: begin
        if (fin.hit) begin
          res_found     = 1'b1;
          res_slot      = fin_hit_slot;
          res_hop_valid = fin.hop_set;
          res_hop       = fin.hop;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      FN_ADD: begin
        priority if (fin.addr == own_address) begin
          res_status = ST_OWN;
        end else if (fin.addr[MCAST_BIT]) begin
          res_status = ST_MCAST;
        end else if (full || !fin.has_free) begin
          res_status = ST_FULL;
        end else if (fin.hit) begin
          res_status = ST_DUP;
        end else begin
          res_slot   = fin_free_slot;
          wr.add     = load;
          wr_slot    = fin_free_slot;
          count_next = load ? count + 1'b1 : count;
        end
      end
      FN_SET_HOP: begin
        // A slot number beyond the table matches no cell, so sel_used stays low.
        if (fin.sel_used) begin
          res_slot      = sidx_wide[IDX_W-1:0];
          res_hop_valid = 1'b1;
          res_hop       = fin.station;
          wr.hop        = load;
          wr_slot       = sidx_wide[IDX_W-1:0];
        end else begin
          res_status = ST_BAD_SLOT;
        end
      end
      FN_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CS_IDLE;
      rsp_valid   <= 1'b0;
      count       <= '0;
      own_address <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg.valid) begin
        own_address <= cfg.own_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      fin           <= tail;
      fin_hit_slot  <= tail_hit_slot;
      fin_free_slot <= tail_free_slot;
    end
    if (load) begin
      out_status    <= res_status;
      out_found     <= res_found;
      out_slot      <= res_slot;
      out_hop_valid <= res_hop_valid;
      out_hop       <= res_hop;
      out_count     <= count_next;
    end
  end

  assign slot_wide  = {5'b0, out_slot};
  assign count_wide = {6'b0, out_count};

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.result_slot = slot_wide[4:0];
  assign rsp.hop_valid   = out_hop_valid;
  assign rsp.hop_station = out_hop;
  assign rsp.path_count  = count_wide[5:0];

endmodule

FILE: hw/rtl/mesh_path_address_table.sv
// Mesh path address table: MAX_PATHS slots, each a cell in a chain. A request
// travels the chain one cell per clock, and a new request is taken only after the
// previous one has left the chain and its outcome has been loaded into the
// response register. The response register lets the next request be accepted
// while the previous response is still waiting.
// The own address register may be written at any time the table is idle.
module mesh_path_address_table #(
  parameter int MAX_PATHS = mpat_pkg::MAX_PATHS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mpat_req_if.sink   req,
  mpat_rsp_if.source rsp,
  mpat_cfg_if.sink   cfg
);
  import mpat_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATHS);

  token_t           tok       [MAX_PATHS+1];
  logic [IDX_W-1:0] hit_slot  [MAX_PATHS+1];
  logic [IDX_W-1:0] free_slot [MAX_PATHS+1];
  wr_t              wr;
  logic [IDX_W-1:0] wr_slot;
  logic [MAX_PATHS-1:0] live;

  assign hit_slot[0]  = '0;
  assign free_slot[0] = '0;

  mpat_ctrl #(.MAX_PATHS(MAX_PATHS)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .cfg            (cfg),
    .head           (tok[0]),
    .tail           (tok[MAX_PATHS]),
    .tail_hit_slot  (hit_slot[MAX_PATHS]),
    .tail_free_slot (free_slot[MAX_PATHS]),
    .wr             (wr),
    .wr_slot        (wr_slot)
  );

  for (genvar i = 0; i < MAX_PATHS; i++) begin : g_cell
    mpat_cell #(.MAX_PATHS(MAX_PATHS), .CELL_IDX(i)) u_cell (
      .clk           (clk),
      .rst           (rst),
      .tok_in        (tok[i]),
      .hit_slot_in   (hit_slot[i]),
      .free_slot_in  (free_slot[i]),
      .tok_out       (tok[i+1]),
      .hit_slot_out  (hit_slot[i+1]),
      .free_slot_out (free_slot[i+1]),
      .wr            (wr),
      .wr_slot       (wr_slot)
    );
    assign live[i] = tok[i+1].valid;
  end

  // Only one request is ever in flight along the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(live) <= 1)
    else $error("more than one request token in the cell chain");

  // An accepted request shows up at the first cell on the next cycle.
  a_launch: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> tok[1].valid)
    else $error("accepted request did not enter the cell chain");

  // While a token walks the chain no new request may be taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    live != '0 |-> !req.ready)
    else $error("request accepted while the chain is busy");

  // A lookup hit always reports success.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (rsp.status == ST_OK))
    else $error("found flag set with an error status");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the mesh path address table: directed rows, then random
// request traffic checked against a behavioral copy of the table.
// Depends on mpat_pkg, the three channel interfaces and the mesh_path_address_table RTL.
module testbench;
  import mpat_pkg::*;

  localparam int TABLE_DEPTH  = MAX_PATHS_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_OPS    = 280;
  localparam int REPORT_CAP   = 60;

  typedef struct packed {
    func_t                func;
    logic [ADDR_W-1:0]    dest;
    logic [SIDX_W-1:0]    sidx;
    logic [STATION_W-1:0] station;
  } path_op_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [SIDX_W-1:0]    slot;
    logic                 hop_valid;
    logic [STATION_W-1:0] hop_station;
    logic [5:0]           path_count;
  } path_result_t;

  typedef struct {
    path_op_t     op;
    bit           typed;
    path_result_t result;
  } stim_row_t;

  logic clk;
  logic rst;

  mpat_req_if req_ch ();
  mpat_rsp_if rsp_ch ();
  mpat_cfg_if cfg_ch ();

  mesh_path_address_table #(.MAX_PATHS(TABLE_DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Behavioral copy of the table contents.
  bit                   path_used    [TABLE_DEPTH];
  logic [ADDR_W-1:0]    path_addr    [TABLE_DEPTH];
  bit                   path_hop_set [TABLE_DEPTH];
  logic [STATION_W-1:0] path_hop     [TABLE_DEPTH];
  int                   path_total;
  logic [ADDR_W-1:0]    own_mac;

  path_result_t pending_results[$];
  stim_row_t    stim_rows[$];
  path_result_t oldest_result;
  int           failures;
  int           reported;
  int           accepted_ops;
  int           cycle_count;
  int           stall_left;
  logic         calm;
  logic         rsp_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic path_result_t apply_table_op(input path_op_t op);
    path_result_t res;
    int hit;
    int free_slot;
    res.status      = ST_OK;
    res.found       = 1'b0;
    res.slot        = '0;
    res.hop_valid   = 1'b0;
    res.hop_station = '0;
    hit = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (path_used[i] && path_addr[i] == op.dest) hit = i;
    end
    case (op.func)
      FN_LOOKUP: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found     = 1'b1;
          res.slot      = hit[SIDX_W-1:0];
          res.hop_valid = path_hop_set[hit];
          if (path_hop_set[hit]) res.hop_station = path_hop[hit];
        end
      end
      FN_ADD: begin
        // Refusals are checked in priority order: own, multicast, full, duplicate.
        if (op.dest == own_mac) begin
          res.status = ST_OWN;
        end else if (op.dest[MCAST_BIT]) begin
          res.status = ST_MCAST;
        end else if (path_total >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_DUP;
        end else begin
          free_slot = -1;
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!path_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            res.status = ST_FULL;
          end else begin
            path_used[free_slot]    = 1'b1;
            path_addr[free_slot]    = op.dest;
            path_hop_set[free_slot] = 1'b0;
            path_hop[free_slot]     = '0;
            path_total++;
            res.slot = free_slot[SIDX_W-1:0];
          end
        end
      end
      FN_SET_HOP: begin
        if (int'(op.sidx) >= TABLE_DEPTH || !path_used[op.sidx]) begin
          res.status = ST_BAD_SLOT;
        end else begin
          path_hop_set[op.sidx] = 1'b1;
          path_hop[op.sidx]     = op.station;
          res.slot        = op.sidx;
          res.hop_valid   = 1'b1;
          res.hop_station = op.station;
        end
      end
      default: ;
    endcase
    res.path_count = path_total[5:0];
    return res;
  endfunction

  function automatic path_op_t random_path_op();
    path_op_t op;
    logic [63:0] wide;
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 35) op.func = FN_LOOKUP;
    else if (pick < 70) op.func = FN_ADD;
    else if (pick < 92) op.func = FN_SET_HOP;
    else op.func = FN_NOP;
    wide = {$urandom(), $urandom()};
    op.dest = wide[ADDR_W-1:0];
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, TABLE_DEPTH - 1);
    if (pick < 40 && path_used[k]) begin
      op.dest = path_addr[k];
    end else if (pick < 50) begin
      op.dest = own_mac;
    end else if (pick >= 75) begin
      // Fresh unicast address, so adds can still land while the table has room.
      op.dest[MCAST_BIT] = 1'b0;
    end
    op.sidx    = SIDX_W'($urandom_range(0, 31));
    op.station = STATION_W'($urandom_range(0, 255));
    return op;
  endfunction

  function automatic int pick_req_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 70) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_row(input func_t func, input logic [ADDR_W-1:0] dest,
                         input int sidx, input int station, input bit typed,
                         input status_t status, input bit found, input int slot,
                         input bit hop_valid, input int hop_station, input int count);
    stim_row_t row;
    row.op.func            = func;
    row.op.dest            = dest;
    row.op.sidx            = sidx[SIDX_W-1:0];
    row.op.station         = station[STATION_W-1:0];
    row.typed              = typed;
    row.result.status      = status;
    row.result.found       = found;
    row.result.slot        = slot[SIDX_W-1:0];
    row.result.hop_valid   = hop_valid;
    row.result.hop_station = hop_station[STATION_W-1:0];
    row.result.path_count  = count[5:0];
    stim_rows.push_back(row);
  endtask

  // Called at a rising edge; returns at the edge where the request was accepted.
  task automatic issue_op(input path_op_t op, input bit typed, input path_result_t typed_res);
    path_result_t predicted;
    req_ch.valid            <= 1'b1;
    req_ch.func             <= op.func;
    req_ch.dest_address     <= op.dest;
    req_ch.slot_index       <= op.sidx;
    req_ch.next_hop_station <= op.station;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_table_op(op);
    pending_results.push_back(typed ? typed_res : predicted);
    accepted_ops++;
  endtask

  task automatic idle_req(input int cycles);
    if (cycles > 0) begin
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results(input bit settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    if (settle) repeat (TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [ADDR_W-1:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.own_address <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    own_mac = value;
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      failures++;
      reported++;
      if (reported <= REPORT_CAP)
        $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        reported++;
        if (reported <= REPORT_CAP) $error("response with no request outstanding");
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", oldest_result.status, rsp_ch.status);
        check_field("found", oldest_result.found, rsp_ch.found);
        check_field("result_slot", oldest_result.slot, rsp_ch.result_slot);
        check_field("hop_valid", oldest_result.hop_valid, rsp_ch.hop_valid);
        check_field("hop_station", oldest_result.hop_station, rsp_ch.hop_station);
        check_field("path_count", oldest_result.path_count, rsp_ch.path_count);
      end
    end
  end

  // Response side: short random stalls, the odd long one, and the forced hold-off.
  initial begin
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && !calm) begin
        case ($urandom_range(0, 99))
          0, 1, 2, 3, 4, 5, 6, 7: stall_left = $urandom_range(1, 3);
          8:                      stall_left = $urandom_range(20, 60);
          default: ;
        endcase
      end
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= !rsp_hold;
      end
    end
  end

  // Stretches with no idling on either side.
  initial begin
    calm <= 1'b0;
    forever begin
      repeat ($urandom_range(300, 1500)) @(posedge clk);
      calm <= 1'b1;
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= 1'b0;
    end
  end

  // Long receiver hold-off while requests keep coming, so the table backs up.
  initial begin
    rsp_hold <= 1'b0;
    wait (accepted_ops >= 300);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] own_settings[5];
    logic [63:0]       wide;
    path_result_t      unused_res;
    failures     = 0;
    reported     = 0;
    accepted_ops = 0;
    path_total   = 0;
    own_mac      = '0;
    unused_res   = '0;
    foreach (path_used[i]) begin
      path_used[i]    = 1'b0;
      path_hop_set[i] = 1'b0;
    end
    rst                     <= 1'b1;
    req_ch.valid            <= 1'b0;
    req_ch.func             <= FN_NOP;
    req_ch.dest_address     <= '0;
    req_ch.slot_index       <= '0;
    req_ch.next_hop_station <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.own_address      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_own_address('0);

    put_row(FN_LOOKUP, 48'h0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
    put_row(FN_ADD, 48'h0, 0, 0, 1, ST_OWN, 0, 0, 0, 0, 0);
    put_row(FN_ADD, 48'h01_00_00_00_00_00, 0, 0, 1, ST_MCAST, 0, 0, 0, 0, 0);
    put_row(FN_SET_HOP, 48'h0, 0, 8'h5A, 1, ST_BAD_SLOT, 0, 0, 0, 0, 0);
    put_row(FN_NOP, 48'hFFFF_FFFF_FFFF, 31, 255, 1, ST_OK, 0, 0, 0, 0, 0);
    put_row(FN_ADD, 48'h00_00_00_00_00_01, 0, 0, 1, ST_OK, 0, 0, 0, 0, 1);
    put_row(FN_ADD, 48'h00_00_00_00_00_01, 0, 0, 1, ST_DUP, 0, 0, 0, 0, 1);
    put_row(FN_LOOKUP, 48'h00_00_00_00_00_01, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
    put_row(FN_SET_HOP, 48'h0, 0, 255, 1, ST_OK, 0, 0, 1, 255, 1);
    put_row(FN_LOOKUP, 48'h00_00_00_00_00_01, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
    put_row(FN_ADD, 48'hFE_FF_FF_FF_FF_FF, 0, 0, 1, ST_OK, 0, 1, 0, 0, 2);
    put_row(FN_SET_HOP, 48'h0, 1, 0, 0, ST_OK, 0, 0, 0, 0, 0);
    put_row(FN_LOOKUP, 48'hFE_FF_FF_FF_FF_FF, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
    put_row(FN_SET_HOP, 48'h0, 31, 8'hA5, 1, ST_BAD_SLOT, 0, 0, 0, 0, 2);
    put_row(FN_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0, 2);
    put_row(FN_ADD, 48'hFFFF_FFFF_FFFF, 0, 0, 1, ST_MCAST, 0, 0, 0, 0, 2);
    put_row(FN_ADD, 48'h02_00_00_00_00_00, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
    put_row(FN_LOOKUP, 48'h0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0, 3);
    put_row(FN_NOP, 48'h0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);

    foreach (stim_rows[i]) begin
      issue_op(stim_rows[i].op, stim_rows[i].typed, stim_rows[i].result);
      idle_req(pick_req_gap());
    end

    // Own address settings: all ones, random unicast, an address already stored,
    // zero, and fully random.
    wide = {$urandom(), $urandom()};
    own_settings[0] = 48'hFFFF_FFFF_FFFF;
    own_settings[1] = {wide[47:41], 1'b0, wide[39:0]};
    own_settings[2] = 48'hFE_FF_FF_FF_FF_FF;
    own_settings[3] = 48'h0;
    wide = {$urandom(), $urandom()};
    own_settings[4] = wide[ADDR_W-1:0];

    foreach (own_settings[p]) begin
      wait_for_results(1);
      write_own_address(own_settings[p]);
      for (int n = 0; n < PHASE_OPS; n++) begin
        issue_op(random_path_op(), 0, unused_res);
        if (p == 2 && n == 120) wait_for_results(0);
        else idle_req(pick_req_gap());
      end
    end

    wait_for_results(1);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mpat_pkg.sv
hw/rtl/mpat_req_if.sv
hw/rtl/mpat_rsp_if.sv
hw/rtl/mpat_cfg_if.sv
hw/rtl/mpat_cell.sv
hw/rtl/mpat_ctrl.sv
hw/rtl/mesh_path_address_table.sv
tb/testbench.sv
